FILE: sv/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg - shared definitions of the bitmask collision tester
// Command codes, configuration register indexes and the coordinate type
// that the control logic and the top level both use.
// ----------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

	// Coordinates are 16-bit signed; two extra bits hold sums with dimensions.
	localparam int COORD_W   = 18;
	localparam int REG_W     = 9;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic [2:0] CMD_LOAD_OWN = 3'd0;
	localparam logic [2:0] CMD_LOAD_OTH = 3'd1;
	localparam logic [2:0] CMD_POINT    = 3'd2;
	localparam logic [2:0] CMD_RECT     = 3'd3;
	localparam logic [2:0] CMD_REGION   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_HEIGHT = 2'd3;

	localparam logic [REG_W-1:0] DIM_RESET = 9'd256;

	// Mask dimensions after clamping to the memory size.
	typedef struct packed {
		coord_t w;
		coord_t h;
		coord_t ow;
		coord_t oh;
	} dims_t;

endpackage

`default_nettype wire

FILE: sv/bct_if.sv
// ----------------------------------------------------------------------------
// bct_if - channel interfaces of the bitmask collision tester
// Query items in, hit result items out, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bct_query_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [7:0]         alpha;
	logic signed [15:0] x_first;
	logic signed [15:0] y_first;
	logic signed [15:0] x_last;
	logic signed [15:0] y_last;

	modport source (output valid, cmd, alpha, x_first, y_first, x_last, y_last,
		input ready);
	modport sink (input valid, cmd, alpha, x_first, y_first, x_last, y_last,
		output ready);
endinterface

interface bct_result_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

FILE: sv/bitmask_collision_tester_core.sv
// ----------------------------------------------------------------------------
// bitmask_collision_tester_core - pixel-exact mask collision tests
// Two 1-bit masks held in row memories; loads set or clear one cell, point,
// rectangle and region tests report whether a set (overlapping) cell exists.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        payload
//   query    in   valid / ready    cmd, alpha, x_first, y_first, x_last, y_last
//   result   out  valid / ready    hit
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One item is worked on at a time. A load goes through the prep and load
// states to its result (row read, modified row written back). A point,
// rectangle or region test scans the mask rows in order after the prep
// state; the scan reads one row of each mask memory per cycle and stops at
// the first hit or after the last row. After reset both masks are cleared
// row by row by a pass during which no item is taken. A stalled result holds in
// the output register while the next item is already accepted.
//
`default_nettype none

module bitmask_collision_tester_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	bct_query_if.sink                            query,
	bct_result_if.source                         result,
	input  wire logic                            cfg_we,
	input  wire logic [bct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bct_pkg::REG_W-1:0]       cfg_data
);

	localparam int RW = $clog2(MAX_HEIGHT);

	logic [bct_pkg::REG_W-1:0] mask_width_q, mask_height_q;
	logic [bct_pkg::REG_W-1:0] other_width_q, other_height_q;
	bct_pkg::dims_t            dims;

	logic [MAX_WIDTH-1:0] own_rd, oth_rd, wdata;
	logic [RW-1:0]        own_raddr, oth_raddr, waddr;
	logic                 own_we, oth_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q   <= bct_pkg::DIM_RESET;
			mask_height_q  <= bct_pkg::DIM_RESET;
			other_width_q  <= bct_pkg::DIM_RESET;
			other_height_q <= bct_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bct_pkg::CFG_MASK_WIDTH:   mask_width_q   <= cfg_data;
				bct_pkg::CFG_MASK_HEIGHT:  mask_height_q  <= cfg_data;
				bct_pkg::CFG_OTHER_WIDTH:  other_width_q  <= cfg_data;
				bct_pkg::CFG_OTHER_HEIGHT: other_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions above the memory size are used as that size.
	function automatic bct_pkg::coord_t clamp_dim(
		input logic [bct_pkg::REG_W-1:0] v,
		input bct_pkg::coord_t           maxv
	);
		bct_pkg::coord_t vs;
		vs = bct_pkg::coord_t'({{(bct_pkg::COORD_W-bct_pkg::REG_W){1'b0}}, v});
		return (vs > maxv) ? maxv : vs;
	endfunction

	always_comb begin
		dims.w  = clamp_dim(mask_width_q,   bct_pkg::coord_t'(MAX_WIDTH));
		dims.h  = clamp_dim(mask_height_q,  bct_pkg::coord_t'(MAX_HEIGHT));
		dims.ow = clamp_dim(other_width_q,  bct_pkg::coord_t'(MAX_WIDTH));
		dims.oh = clamp_dim(other_height_q, bct_pkg::coord_t'(MAX_HEIGHT));
	end

	bct_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.result    (result),
		.dims      (dims),
		.own_rd    (own_rd),
		.oth_rd    (oth_rd),
		.own_raddr (own_raddr),
		.oth_raddr (oth_raddr),
		.own_we    (own_we),
		.oth_we    (oth_we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	bct_mask_mem #(
		.DEPTH (MAX_HEIGHT),
		.WIDTH (MAX_WIDTH)
	) u_own_mem (
		.clk   (clk),
		.we    (own_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (own_raddr),
		.rdata (own_rd)
	);

	bct_mask_mem #(
		.DEPTH (MAX_HEIGHT),
		.WIDTH (MAX_WIDTH)
	) u_oth_mem (
		.clk   (clk),
		.we    (oth_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (oth_raddr),
		.rdata (oth_rd)
	);

	// Both masks are written together only by the clearing pass.
	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		own_we && oth_we |-> !query.ready)
		else $error("item taken while both masks are being cleared");

	// A single-mask write belongs to a load in flight.
	a_load_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		own_we != oth_we |-> !query.ready)
		else $error("mask row written while idle");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		query.valid && query.ready |=> !query.ready)
		else $error("second item taken while one is in flight");

endmodule

`default_nettype wire

FILE: sv/bct_mask_mem.sv
// ----------------------------------------------------------------------------
// bct_mask_mem - one collision mask, stored one row per word
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_mask_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl - command sequencer of the bitmask collision tester
// Clears both masks after reset, does read-modify-write row updates for
// loads, and scans mask rows one per cycle for point, rectangle and
// region tests.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_ctrl #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bct_query_if.sink                          query,
	bct_result_if.source                       result,
	input  wire bct_pkg::dims_t                dims,
	input  wire logic [MAX_WIDTH-1:0]          own_rd,
	input  wire logic [MAX_WIDTH-1:0]          oth_rd,
	output      logic [$clog2(MAX_HEIGHT)-1:0] own_raddr,
	output      logic [$clog2(MAX_HEIGHT)-1:0] oth_raddr,
	output      logic                          own_we,
	output      logic                          oth_we,
	output      logic [$clog2(MAX_HEIGHT)-1:0] waddr,
	output      logic [MAX_WIDTH-1:0]          wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_LOAD,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [RW-1:0]     clr_q;
	logic              issuing_q;
	logic              issue_s1;
	logic              last_s1;
	logic              hit_q;
	logic              out_valid_q;
	logic              out_hit_q;

	logic [2:0]         cmd_q;
	logic               opaque_q;
	logic signed [15:0] xf_q;
	logic signed [15:0] yf_q;
	logic signed [15:0] xl_q;
	logic signed [15:0] yl_q;
	logic               tgt_oth_q;
	logic               region_q;
	logic               shl_q;
	logic [CW-1:0]      sha_q;
	logic [CW-1:0]      x0_q;
	logic [CW-1:0]      x1_q;
	logic [RW-1:0]      y_q;
	logic [RW-1:0]      y1_q;

	bct_pkg::coord_t xf, yf, xl_e, yl_e, x0, y0, x1, y1;
	bct_pkg::coord_t rx1, ry1, gx1, gy1, bw, bh, nxf;
	logic            is_region, nonempty, load_inb;

	logic [MAX_WIDTH-1:0] colmask, aligned, row_bits, bit_sel, base_row, new_row;
	logic                 row_any;

	// Bounds of the query, from the captured item and the clamped dimensions.
	always_comb begin
		xf   = bct_pkg::coord_t'(xf_q);
		yf   = bct_pkg::coord_t'(yf_q);
		xl_e = (cmd_q == bct_pkg::CMD_POINT) ? xf : bct_pkg::coord_t'(xl_q);
		yl_e = (cmd_q == bct_pkg::CMD_POINT) ? yf : bct_pkg::coord_t'(yl_q);
		is_region = (cmd_q == bct_pkg::CMD_REGION);

		x0 = (xf > 0) ? xf : '0;
		y0 = (yf > 0) ? yf : '0;
		rx1 = (xl_e < dims.w - 1) ? xl_e : bct_pkg::coord_t'(dims.w - 1);
		ry1 = (yl_e < dims.h - 1) ? yl_e : bct_pkg::coord_t'(dims.h - 1);
		gx1 = bct_pkg::coord_t'(((xf + dims.ow < dims.w) ? xf + dims.ow : dims.w) - 1);
		gy1 = bct_pkg::coord_t'(((yf + dims.oh < dims.h) ? yf + dims.oh : dims.h) - 1);
		x1 = is_region ? gx1 : rx1;
		y1 = is_region ? gy1 : ry1;
		nonempty = (x0 <= x1) && (y0 <= y1);

		bw = (cmd_q == bct_pkg::CMD_LOAD_OWN) ? dims.w : dims.ow;
		bh = (cmd_q == bct_pkg::CMD_LOAD_OWN) ? dims.h : dims.oh;
		load_inb = (xf >= 0) && (yf >= 0) && (xf < bw) && (yf < bh);
		nxf = -xf;
	end

	// Evaluation of one fetched row: the other row is aligned to the own
	// mask columns by the region offset, then both are limited to the
	// column span of the query.
	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			colmask[i] = (CW'(i) >= x0_q) && (CW'(i) <= x1_q);
		end
		aligned  = shl_q ? (oth_rd << sha_q) : (oth_rd >> sha_q);
		row_bits = own_rd & colmask & (region_q ? aligned : {MAX_WIDTH{1'b1}});
		row_any  = |row_bits;
	end

	// Row update for a load.
	always_comb begin
		bit_sel  = {{(MAX_WIDTH-1){1'b0}}, 1'b1} << xf_q[CW-1:0];
		base_row = tgt_oth_q ? oth_rd : own_rd;
		new_row  = opaque_q ? (base_row | bit_sel) : (base_row & ~bit_sel);
	end

	always_comb begin
		own_raddr = (state_q == S_SCAN) ? y_q : yf_q[RW-1:0];
		oth_raddr = (state_q == S_SCAN) ? (y_q - yf_q[RW-1:0]) : yf_q[RW-1:0];
		waddr     = (state_q == S_CLEAR) ? clr_q : yf_q[RW-1:0];
		wdata     = (state_q == S_CLEAR) ? '0 : new_row;
		own_we    = (state_q == S_CLEAR) || ((state_q == S_LOAD) && !tgt_oth_q);
		oth_we    = (state_q == S_CLEAR) || ((state_q == S_LOAD) && tgt_oth_q);
	end

	assign query.ready  = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.hit   = out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			issuing_q   <= 1'b0;
			issue_s1    <= 1'b0;
			last_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else begin
			// The output register takes a new result once the old one has left.
			if ((state_q == S_DONE) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RW'(MAX_HEIGHT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (query.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					hit_q     <= 1'b0;
					issue_s1  <= 1'b0;
					issuing_q <= 1'b1;
					case (cmd_q) inside
						bct_pkg::CMD_LOAD_OWN, bct_pkg::CMD_LOAD_OTH: begin
							state_q <= load_inb ? S_LOAD : S_DONE;
						end
						bct_pkg::CMD_POINT, bct_pkg::CMD_RECT, bct_pkg::CMD_REGION: begin
							state_q <= nonempty ? S_SCAN : S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					issue_s1 <= issuing_q;
					if (issuing_q) begin
						last_s1   <= (y_q == y1_q);
						issuing_q <= (y_q != y1_q);
					end
					// A row read last cycle is evaluated now; stop on the
					// first hit or after the last row.
					if (issue_s1 && (row_any || last_s1)) begin
						hit_q   <= row_any;
						state_q <= S_DONE;
					end
				end
				S_LOAD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item and query payload registers.
	always_ff @(posedge clk) begin
		if (query.valid && query.ready) begin
			cmd_q    <= query.cmd;
			opaque_q <= (query.alpha != 8'd0);
			xf_q     <= query.x_first;
			yf_q     <= query.y_first;
			xl_q     <= query.x_last;
			yl_q     <= query.y_last;
		end
		if (state_q == S_PREP) begin
			tgt_oth_q <= (cmd_q == bct_pkg::CMD_LOAD_OTH);
			region_q  <= is_region;
			shl_q     <= (xf >= 0);
			sha_q     <= (xf >= 0) ? xf[CW-1:0] : nxf[CW-1:0];
			x0_q      <= x0[CW-1:0];
			x1_q      <= x1[CW-1:0];
			y_q       <= y0[RW-1:0];
			y1_q      <= y1[RW-1:0];
		end else if (state_q == S_SCAN && issuing_q) begin
			y_q <= y_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking testbench of bitmask_collision_tester_core
// Loads both masks and runs point, rectangle and region tests over a series
// of mask sizes, with random sender bursts and receiver stalls. Every hit is
// compared with a fixed expected value or an in-bench model with its own copy of both masks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W             = 256;
	localparam int MAX_H             = 256;
	localparam int SCAN_LATENCY      = MAX_H + 8;
	localparam int STALL_LIMIT       = 4000;
	localparam int HOLD_CYCLES       = 600;
	localparam int HOLD_SETTING      = 3;
	localparam int NUM_SETTINGS      = 14;
	localparam int ITEMS_PER_SETTING = 84;
	localparam int WINDOW            = 24;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [7:0]         alpha;
		logic signed [15:0] x_first;
		logic signed [15:0] y_first;
		logic signed [15:0] x_last;
		logic signed [15:0] y_last;
	} query_t;

	typedef struct packed {
		query_t q;
		logic   known;
		logic   hit;
	} directed_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bct_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bct_pkg::REG_W-1:0]     cfg_data;

	bct_query_if  qif ();
	bct_result_if rif ();

	bitmask_collision_tester_core #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (qif),
		.result    (rif),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model copy of both masks, one row vector per mask row.
	logic [MAX_W-1:0]          own_rows   [MAX_H];
	logic [MAX_W-1:0]          other_rows [MAX_H];
	logic [bct_pkg::REG_W-1:0] dim_regs   [4];

	bit hits_due [$];
	int errors       = 0;
	int n_hits       = 0;
	int n_loads      = 0;
	int n_tests      = 0;
	int n_settings   = 0;
	int idle_cycles  = 0;

	directed_row_t directed_rows [0:26] = '{
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_RECT, 8'd0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff},
			1'b1, 1'b0},
		'{'{bct_pkg::CMD_REGION, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_LOAD_OWN, 8'd255, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_LOAD_OWN, 8'd1, 16'sd255, 16'sd255, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		// Loads outside the mask must be dropped.
		'{'{bct_pkg::CMD_LOAD_OWN, 8'd255, 16'sd256, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_LOAD_OWN, 8'd255, -16'sd1, 16'sd5, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sd255, 16'sd255, 16'sd0, 16'sd0}, 1'b1, 1'b1},
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		// Reversed rectangle is empty.
		'{'{bct_pkg::CMD_RECT, 8'd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_RECT, 8'd0, -16'sd100, -16'sd100, 16'sd0, 16'sd0}, 1'b1, 1'b1},
		'{'{bct_pkg::CMD_RECT, 8'd0, 16'sd1, 16'sd1, 16'sd254, 16'sd254}, 1'b0, 1'b0},
		'{'{bct_pkg::CMD_RECT, 8'd0, 16'sd200, 16'sd200, 16'sh7fff, 16'sh7fff},
			1'b0, 1'b0},
		'{'{bct_pkg::CMD_LOAD_OTH, 8'd128, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_REGION, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
		'{'{bct_pkg::CMD_REGION, 8'd0, 16'sd255, 16'sd255, 16'sd0, 16'sd0}, 1'b0, 1'b0},
		// Offset just past the right edge: no overlap at all.
		'{'{bct_pkg::CMD_REGION, 8'd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_REGION, 8'd0, -16'sd255, -16'sd255, 16'sd0, 16'sd0}, 1'b0, 1'b0},
		'{'{bct_pkg::CMD_LOAD_OTH, 8'd1, 16'sd255, 16'sd255, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_REGION, 8'd0, -16'sd255, -16'sd255, 16'sd0, 16'sd0}, 1'b0, 1'b0},
		// A zero alpha clears the cell again.
		'{'{bct_pkg::CMD_LOAD_OWN, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_POINT, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{bct_pkg::CMD_REGION, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0},
		'{'{CMD_SPARE_FIRST, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0},
		'{'{CMD_SPARE_LAST, 8'd255, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
			1'b1, 1'b0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(logic [bct_pkg::REG_W-1:0] v, int maxv);
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	function automatic logic [MAX_W-1:0] col_span(int lo, int hi);
		return ({MAX_W{1'b1}} << lo) & ({MAX_W{1'b1}} >> (MAX_W - 1 - hi));
	endfunction

	// Applies one query to the model masks and returns the hit it must give.
	function automatic bit predict_hit(query_t q);
		int w, h, ow, oh, xf, yf, xl, yl, x0, y0, x1, y1, y;
		logic [MAX_W-1:0] cols, other_part;
		bit found;
		w  = clamp_dim(dim_regs[bct_pkg::CFG_MASK_WIDTH], MAX_W);
		h  = clamp_dim(dim_regs[bct_pkg::CFG_MASK_HEIGHT], MAX_H);
		ow = clamp_dim(dim_regs[bct_pkg::CFG_OTHER_WIDTH], MAX_W);
		oh = clamp_dim(dim_regs[bct_pkg::CFG_OTHER_HEIGHT], MAX_H);
		xf = int'($signed(q.x_first));
		yf = int'($signed(q.y_first));
		xl = int'($signed(q.x_last));
		yl = int'($signed(q.y_last));
		found = 1'b0;
		case (q.cmd)
			bct_pkg::CMD_LOAD_OWN: begin
				if (xf >= 0 && yf >= 0 && xf < w && yf < h)
					own_rows[yf][xf] = (q.alpha != 8'd0);
			end
			bct_pkg::CMD_LOAD_OTH: begin
				if (xf >= 0 && yf >= 0 && xf < ow && yf < oh)
					other_rows[yf][xf] = (q.alpha != 8'd0);
			end
			bct_pkg::CMD_POINT: begin
				if (xf >= 0 && yf >= 0 && xf < w && yf < h)
					found = own_rows[yf][xf];
			end
			bct_pkg::CMD_RECT: begin
				x0 = (xf > 0) ? xf : 0;
				y0 = (yf > 0) ? yf : 0;
				x1 = (xl < w - 1) ? xl : w - 1;
				y1 = (yl < h - 1) ? yl : h - 1;
				if (x0 <= x1 && y0 <= y1) begin
					cols = col_span(x0, x1);
					for (y = y0; y <= y1 && !found; y++)
						found = |(own_rows[y] & cols);
				end
			end
			bct_pkg::CMD_REGION: begin
				x0 = (xf > 0) ? xf : 0;
				y0 = (yf > 0) ? yf : 0;
				x1 = ((xf + ow < w) ? xf + ow : w) - 1;
				y1 = ((yf + oh < h) ? yf + oh : h) - 1;
				if (x0 <= x1 && y0 <= y1) begin
					cols = col_span(x0, x1);
					for (y = y0; y <= y1 && !found; y++) begin
						// Line the other row up so that bit x holds other cell x - xf.
						other_part = (xf >= 0) ? other_rows[y - yf] << xf
							: other_rows[y - yf] >> (-xf);
						found = |(own_rows[y] & other_part & cols);
					end
				end
			end
			default: found = 1'b0;
		endcase
		return found;
	endfunction

	// Mostly cells near the origin, so that loads and tests meet often.
	function automatic int pick_coord(int span);
		int lim;
		lim = (span < WINDOW) ? span : WINDOW;
		case ($urandom_range(0, 19))
			0: return int'($urandom_range(0, 65535)) - 32768;
			1: return -int'($urandom_range(1, 4));
			2: return span + int'($urandom_range(0, 3));
			3: return span - 1;
			4, 5: return int'($urandom_range(0, (span > 0) ? span - 1 : 0));
			default: return int'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
		endcase
	endfunction

	function automatic int pick_offset(int other_span, int own_span);
		case ($urandom_range(0, 15))
			0: return int'($urandom_range(0, 65535)) - 32768;
			1: return own_span;
			2: return -other_span;
			3: return own_span - 1;
			4: return 1 - other_span;
			default: return int'($urandom_range(0, 2 * WINDOW)) - WINDOW;
		endcase
	endfunction

	function automatic int rect_edge(int first);
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 65535)) - 32768;
			1: return first - int'($urandom_range(1, 6));
			default: return first + int'($urandom_range(0, 12));
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int w, h, ow, oh, r, xf, yf;
		w  = clamp_dim(dim_regs[bct_pkg::CFG_MASK_WIDTH], MAX_W);
		h  = clamp_dim(dim_regs[bct_pkg::CFG_MASK_HEIGHT], MAX_H);
		ow = clamp_dim(dim_regs[bct_pkg::CFG_OTHER_WIDTH], MAX_W);
		oh = clamp_dim(dim_regs[bct_pkg::CFG_OTHER_HEIGHT], MAX_H);
		r = int'($urandom_range(0, 99));
		q.cmd = (r < 22) ? bct_pkg::CMD_LOAD_OWN
			: (r < 40) ? bct_pkg::CMD_LOAD_OTH
			: (r < 55) ? bct_pkg::CMD_POINT
			: (r < 75) ? bct_pkg::CMD_RECT
			: (r < 95) ? bct_pkg::CMD_REGION
			: 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		q.alpha  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		q.x_last = 16'($urandom);
		q.y_last = 16'($urandom);
		case (q.cmd)
			bct_pkg::CMD_LOAD_OTH: begin
				xf = pick_coord(ow);
				yf = pick_coord(oh);
			end
			bct_pkg::CMD_REGION: begin
				xf = pick_offset(ow, w);
				yf = pick_offset(oh, h);
			end
			default: begin
				xf = pick_coord(w);
				yf = pick_coord(h);
			end
		endcase
		if (q.cmd == bct_pkg::CMD_RECT) begin
			q.x_last = 16'(rect_edge(xf));
			q.y_last = 16'(rect_edge(yf));
		end
		q.x_first = 16'(xf);
		q.y_first = 16'(yf);
		return q;
	endfunction

	function automatic logic [bct_pkg::REG_W-1:0] random_dim();
		case ($urandom_range(0, 19))
			0: return 9'd0;
			1: return 9'($urandom_range(257, 511));
			2: return bct_pkg::DIM_RESET;
			default: return 9'($urandom_range(1, 40));
		endcase
	endfunction

	// Holds the query until it is taken, then records the hit it must give.
	task automatic offer(query_t q, bit use_known, bit known_hit);
		bit predicted;
		qif.valid   <= 1'b1;
		qif.cmd     <= q.cmd;
		qif.alpha   <= q.alpha;
		qif.x_first <= q.x_first;
		qif.y_first <= q.y_first;
		qif.x_last  <= q.x_last;
		qif.y_last  <= q.y_last;
		@(posedge clk);
		while (!qif.ready)
			@(posedge clk);
		predicted = predict_hit(q);
		hits_due = {hits_due, (use_known ? known_hit : predicted)};
		if (q.cmd == bct_pkg::CMD_LOAD_OWN || q.cmd == bct_pkg::CMD_LOAD_OTH)
			n_loads++;
		else if (q.cmd <= bct_pkg::CMD_REGION)
			n_tests++;
	endtask

	task automatic pause_sender(int cycles);
		qif.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		qif.valid <= 1'b0;
		while (hits_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dims(logic [bct_pkg::REG_W-1:0] w, logic [bct_pkg::REG_W-1:0] h,
		logic [bct_pkg::REG_W-1:0] ow, logic [bct_pkg::REG_W-1:0] oh);
		logic [bct_pkg::REG_W-1:0] vals [4];
		logic [bct_pkg::CFG_IDX_W-1:0] regs [4];
		int i;
		vals = '{w, h, ow, oh};
		regs = '{bct_pkg::CFG_MASK_WIDTH, bct_pkg::CFG_MASK_HEIGHT,
			bct_pkg::CFG_OTHER_WIDTH, bct_pkg::CFG_OTHER_HEIGHT};
		for (i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			dim_regs[regs[i]] = vals[i];
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin : check_hits
		bit want;
		if (rif.valid && rif.ready) begin
			if (rif.hit)
				n_hits++;
			if (hits_due.size() == 0) begin
				$display("%0t: hit result %0b arrived with no query outstanding",
					$time, rif.hit);
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (rif.hit !== want) begin
					$display("%0t: hit mismatch, expected %0b, actual %0b",
						$time, want, rif.hit);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((qif.valid && qif.ready) || (rif.valid && rif.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d hits outstanding",
				$time, STALL_LIMIT, hits_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: stall patterns that change now and then, plus one long
	// hold-off once the full-size mask setting is in.
	initial begin : result_stalls
		int mode;
		int mode_left;
		int hold_left;
		int cyc;
		bit hold_done;
		mode = 0;
		mode_left = 200;
		hold_left = 0;
		cyc = 0;
		hold_done = 1'b0;
		rif.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			mode_left--;
			if (mode_left == 0) begin
				mode = int'($urandom_range(0, 3));
				mode_left = int'($urandom_range(50, 400));
			end
			if (!hold_done && n_settings == HOLD_SETTING) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rif.ready <= 1'b0;
			end else begin
				case (mode)
					0: rif.ready <= 1'b1;
					1: rif.ready <= ($urandom_range(0, 3) != 0);
					2: rif.ready <= ($urandom_range(0, 3) == 0);
					default: rif.ready <= (cyc % 3 != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		query_t q;
		int i, s, n, burst_left;
		bit no_gaps;
		qif.valid   <= 1'b0;
		qif.cmd     <= bct_pkg::CMD_LOAD_OWN;
		qif.alpha   <= 8'd0;
		qif.x_first <= 16'sd0;
		qif.y_first <= 16'sd0;
		qif.x_last  <= 16'sd0;
		qif.y_last  <= 16'sd0;
		cfg_we      <= 1'b0;
		cfg_index   <= bct_pkg::CFG_MASK_WIDTH;
		cfg_data    <= bct_pkg::DIM_RESET;
		arst_n      <= 1'b0;
		for (i = 0; i < MAX_H; i++) begin
			own_rows[i]   = '0;
			other_rows[i] = '0;
		end
		for (i = 0; i < 4; i++)
			dim_regs[i] = bct_pkg::DIM_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(directed_rows); i++) begin
			offer(directed_rows[i].q, directed_rows[i].known, directed_rows[i].hit);
			if ($urandom_range(0, 3) == 0)
				pause_sender(int'($urandom_range(1, 6)));
		end
		drain();

		for (s = 0; s < NUM_SETTINGS; s++) begin
			case (s)
				0: write_dims(9'd1, 9'd1, 9'd1, 9'd1);
				1: write_dims(9'd0, bct_pkg::DIM_RESET, bct_pkg::DIM_RESET,
					bct_pkg::DIM_RESET);
				2: write_dims(bct_pkg::DIM_RESET, bct_pkg::DIM_RESET, bct_pkg::DIM_RESET,
					bct_pkg::DIM_RESET);
				3: write_dims(9'd511, 9'd511, 9'd511, 9'd511);
				4: write_dims(9'd20, 9'd0, 9'd30, 9'd0);
				5: write_dims(9'd16, 9'd12, 9'd0, 9'd9);
				default: write_dims(random_dim(), random_dim(), random_dim(), random_dim());
			endcase
			no_gaps = (s % 4 == 1);
			burst_left = int'($urandom_range(1, 24));
			n = 0;
			while (n < ITEMS_PER_SETTING) begin
				q = random_query();
				offer(q, 1'b0, 1'b0);
				if (q.cmd <= bct_pkg::CMD_REGION)
					n++;
				burst_left--;
				if (burst_left == 0) begin
					if (!no_gaps)
						pause_sender(int'($urandom_range(1, 12)));
					burst_left = int'($urandom_range(1, 24));
				end
			end
			drain();
		end

		repeat (SCAN_LATENCY) @(posedge clk);
		$display("Covered %0d loads and %0d point/rectangle/region tests (%0d hits)",
			n_loads, n_tests, n_hits);
		$display("across %0d mask size settings, including zero and oversized ones",
			n_settings);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
